### src/cartridge_bank_controller_core_defines.svh
// assertion macros shared by the cartridge bank controller checker
`ifndef CARTRIDGE_BANK_CONTROLLER_CORE_DEFINES_SVH
`define CARTRIDGE_BANK_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define CBC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cartridge bank controller check failed");

// next-cycle implication, checked while out of reset
`define CBC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cartridge bank controller check failed");

`endif

### src/cbc_pkg.sv
// shared types, constants and helpers of the cartridge bank controller
package cbc_pkg;

  localparam int AddrW    = 16;
  localparam int DataW    = 8;
  localparam int RomBankW = 7;
  localparam int RamBankW = 2;
  localparam int InTdataW  = 24;
  localparam int OutTdataW = 16;

  // controller kind codes
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_MBC1 = 2'd1,
    KIND_MBC2 = 2'd2,
    KIND_MBC3 = 2'd3
  } kind_t;

  // upper address bits that pick the 8 KiB write window
  localparam logic [2:0] WIN_RAM_EN = 3'd0;
  localparam logic [2:0] WIN_ROM_LO = 3'd1;
  localparam logic [2:0] WIN_BANK2  = 3'd2;
  localparam logic [2:0] WIN_MODE   = 3'd3;

  localparam logic [3:0] RAM_EN_KEY = 4'hA;

  // one accepted bus write
  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] wdata;
  } bus_wr_t;

  // one result beat
  typedef struct packed {
    logic [RomBankW-1:0] rom_bank;
    logic [RamBankW-1:0] ram_bank;
    logic                ram_enabled;
    logic                rom_changed;
    logic                ram_changed;
  } result_t;

  // bank zero maps to bank one
  function automatic logic [RomBankW-1:0] fix_zero(input logic [RomBankW-1:0] bank);
    fix_zero = (bank == '0) ? RomBankW'(1) : bank;
  endfunction

endpackage

### src/cbc_in_stage.sv
// input register stage: holds one accepted bus write
module cbc_in_stage (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [cbc_pkg::InTdataW-1:0] in_tdata,  // addr[15:0], wdata[23:16]
  input  logic                    advance,
  output logic                    s1_valid,
  output cbc_pkg::bus_wr_t        s1_wr
);

  logic             valid_r, valid_nxt;
  cbc_pkg::bus_wr_t wr_r;

  // stage takes a beat when empty or when its item moves on
  assign in_tready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      wr_r.addr  <= in_tdata[cbc_pkg::AddrW-1:0];
      wr_r.wdata <= in_tdata[cbc_pkg::AddrW +: cbc_pkg::DataW];
    end
  end

  assign s1_valid = valid_r;
  assign s1_wr    = wr_r;

endmodule

### src/cbc_bank_update.sv
// bank state registers and the write decode that updates them
module cbc_bank_update (
  input  logic              clk,
  input  logic              rst_n,
  input  cbc_pkg::kind_t    kind,
  input  logic              step,
  input  cbc_pkg::bus_wr_t  wr,
  output cbc_pkg::result_t  res
);

  logic [cbc_pkg::RomBankW-1:0] rom_bank_r, rom_bank_nxt;
  logic [cbc_pkg::RamBankW-1:0] ram_bank_r, ram_bank_nxt;
  logic                         ram_en_r, ram_en_nxt;
  logic                         rom_mode_r, rom_mode_nxt;
  logic [2:0]                   win;
  logic                         en_key;

  assign win    = wr.addr[cbc_pkg::AddrW-1 -: 3];
  assign en_key = (wr.wdata[3:0] == cbc_pkg::RAM_EN_KEY);

  // decode the write per controller kind
  always_comb begin
    rom_bank_nxt = rom_bank_r;
    ram_bank_nxt = ram_bank_r;
    ram_en_nxt   = ram_en_r;
    rom_mode_nxt = rom_mode_r;
    case (kind)
      cbc_pkg::KIND_MBC1: begin
        if (win == cbc_pkg::WIN_RAM_EN) begin
          ram_en_nxt = en_key;
        end else if (win == cbc_pkg::WIN_ROM_LO) begin
          rom_bank_nxt = cbc_pkg::fix_zero({rom_bank_r[6:5], wr.wdata[4:0]});
        end else if (win == cbc_pkg::WIN_BANK2) begin
          if (!rom_mode_r) begin
            ram_bank_nxt = wr.wdata[1:0];
          end else begin
            rom_bank_nxt = cbc_pkg::fix_zero({wr.wdata[1:0], rom_bank_r[4:0]});
          end
        end else if (win == cbc_pkg::WIN_MODE) begin
          rom_mode_nxt = !wr.wdata[0];
        end
      end
      cbc_pkg::KIND_MBC2: begin
        if (wr.addr[15:14] == 2'b00) begin
          if (wr.addr[8]) begin
            rom_bank_nxt = cbc_pkg::fix_zero({rom_bank_r[6:4], wr.wdata[3:0]});
          end else begin
            ram_en_nxt = en_key;
          end
        end
      end
      cbc_pkg::KIND_MBC3: begin
        if (win == cbc_pkg::WIN_RAM_EN) begin
          ram_en_nxt = en_key;
        end else if (win == cbc_pkg::WIN_ROM_LO) begin
          rom_bank_nxt = cbc_pkg::fix_zero(wr.wdata[6:0]);
        end else if (win == cbc_pkg::WIN_BANK2) begin
          ram_bank_nxt = wr.wdata[1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // state registers advance once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_bank_r <= cbc_pkg::RomBankW'(1);
      ram_bank_r <= '0;
      ram_en_r   <= 1'b0;
      rom_mode_r <= 1'b1;
    end else if (step) begin
      rom_bank_r <= rom_bank_nxt;
      ram_bank_r <= ram_bank_nxt;
      ram_en_r   <= ram_en_nxt;
      rom_mode_r <= rom_mode_nxt;
    end
  end

  // result of this write
  always_comb begin
    res.rom_bank    = rom_bank_nxt;
    res.ram_bank    = ram_bank_nxt;
    res.ram_enabled = ram_en_nxt;
    res.rom_changed = (rom_bank_nxt != rom_bank_r);
    res.ram_changed = (ram_bank_nxt != ram_bank_r);
  end

endmodule

### src/cbc_out_stage.sv
// result register stage feeding the output channel
module cbc_out_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          s1_valid,
  input  cbc_pkg::result_t              res,
  output logic                          advance,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // rom_bank[6:0], ram_bank[8:7], ram_enabled[9], rom_changed[10], ram_changed[11]
  output logic [cbc_pkg::OutTdataW-1:0] out_tdata
);

  logic             valid_r, valid_nxt;
  cbc_pkg::result_t res_r;

  // a held result leaves or the register is empty
  assign advance = s1_valid && (!valid_r || out_tready);

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  // pack fields from the low bit up
  assign out_tvalid = valid_r;
  assign out_tdata  = {4'b0000, res_r.ram_changed, res_r.rom_changed, res_r.ram_enabled,
                       res_r.ram_bank, res_r.rom_bank};

endmodule

### src/cartridge_bank_controller_core.sv
// top level of the cartridge bank controller
// Cartridge bank controller core.
// in_ channel: one beat per processor write into the cartridge area,
//   in_tdata = addr[15:0], wdata[23:16].
// out_ channel: one beat per input beat, in order, carrying the ROM bank,
//   RAM bank and RAM enable after the write plus ROM/RAM bank changed flags.
// cfg_ channel: writes the controller kind (0 none, 1 MBC1, 2 MBC2, 3 MBC3);
//   always ready, and meant to be written only while the block is idle.
// Path: an input beat is held in the input register, then decoded into the
//   result register.
// Throughput: one beat per cycle while out_tready is high; the bank decode is a
//   single short path between the two registers, so both stages move every cycle.
// Reset (rst_n low, synchronous): both stages empty, kind none, ROM bank 1,
//   RAM bank 0, RAM disabled, MBC1 in ROM banking mode.
// Stall: when out_tready is low the result holds on out_tdata; one more beat
//   is taken into the input register, then in_tready drops until the result
//   is taken.
module cartridge_bank_controller_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [cbc_pkg::InTdataW-1:0]  in_tdata,   // addr[15:0], wdata[23:16]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // rom_bank[6:0], ram_bank[8:7], ram_enabled[9], rom_changed[10], ram_changed[11]
  output logic [cbc_pkg::OutTdataW-1:0] out_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_data     // controller_kind[1:0]
);

  cbc_pkg::kind_t   kind_r;
  logic             s1_valid;
  logic             advance;
  cbc_pkg::bus_wr_t s1_wr;
  cbc_pkg::result_t res;

  // controller kind register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= cbc_pkg::KIND_NONE;
    end else if (cfg_valid && cfg_ready) begin
      kind_r <= cbc_pkg::kind_t'(cfg_data);
    end
  end

  cbc_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .advance   (advance),
    .s1_valid  (s1_valid),
    .s1_wr     (s1_wr)
  );

  cbc_bank_update u_bank (
    .clk   (clk),
    .rst_n (rst_n),
    .kind  (kind_r),
    .step  (advance),
    .wr    (s1_wr),
    .res   (res)
  );

  cbc_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid),
    .res        (res),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### src/cbc_checker.sv
// port-level checks for the cartridge bank controller, bound to the top level
`include "cartridge_bank_controller_core_defines.svh"

module cbc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [cbc_pkg::OutTdataW-1:0] out_tdata
);

  // a stalled result stays put
  `CBC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // the mapped ROM bank is never zero
  `CBC_ASSERT_SAME(a_rom_nonzero, out_tvalid, out_tdata[6:0] != 7'd0)

  // padding bits of the result stay clear
  `CBC_ASSERT_SAME(a_pad_zero, out_tvalid, out_tdata[15:12] == 4'd0)

  // an accepted write moves on from the input register into the result register when the sink is ready
  `CBC_ASSERT_NEXT(a_latency, (in_tvalid && in_tready) ##1 out_tready, out_tvalid)

endmodule

bind cartridge_bank_controller_core cbc_checker u_cbc_checker (.*);

### test/tb_top.sv
// self-checking testbench for the cartridge bank controller core
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cbc_pkg::*;

  localparam int QuietLimit   = 1000;
  localparam int DrainCycles  = 4;
  localparam int HoldCycles   = 60;
  localparam int HoldAfter    = 150;
  localparam int MbcItems     = 130;
  localparam int NoneItems    = 20;
  localparam int MaxReports   = 10;

  // banking state as the testbench tracks it
  typedef struct {
    kind_t                kind;
    logic [RomBankW-1:0]  rom;
    logic [RamBankW-1:0]  ram;
    logic                 ram_en;
    logic                 rom_mode;
  } bank_state_t;

  // one directed bus write, with an optional hand-written result
  typedef struct {
    kind_t          kind;
    logic [15:0]    addr;
    logic [7:0]     wdata;
    bit             typed;
    result_t        want;
  } dir_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [InTdataW-1:0]  in_tdata;   // addr[15:0], wdata[23:16]
  logic                 out_tvalid;
  logic                 out_tready;
  // rom_bank[6:0], ram_bank[8:7], ram_enabled[9], rom_changed[10], ram_changed[11]
  logic [OutTdataW-1:0] out_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [1:0]           cfg_data;   // controller_kind[1:0]

  bank_state_t  mirror;
  result_t      expected_banks[$];
  dir_row_t     dir_rows[$];

  int  send_idle_pct;
  int  recv_stall_pct;
  int  writes_sent;
  int  results_checked;
  int  kind_writes;
  int  mismatches;
  int  quiet_cycles;
  bit  hold_done;

  cartridge_bank_controller_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // bank register update for one bus write, returns the result beat
  function automatic result_t bank_update(inout bank_state_t s, input logic [15:0] a,
                                          input logic [7:0] d);
    logic [RomBankW-1:0] old_rom;
    logic [RamBankW-1:0] old_ram;
    logic [RomBankW-1:0] rom_next;
    bit                  rom_write;
    result_t             r;
    old_rom   = s.rom;
    old_ram   = s.ram;
    rom_next  = s.rom;
    rom_write = 1'b0;
    case (s.kind)
      KIND_MBC1: begin
        if (a < 16'h2000) begin
          s.ram_en = (d[3:0] == RAM_EN_KEY);
        end else if (a < 16'h4000) begin
          rom_next  = {s.rom[6:5], d[4:0]};
          rom_write = 1'b1;
        end else if (a < 16'h6000) begin
          if (!s.rom_mode) begin
            s.ram = d[1:0];
          end else begin
            rom_next  = {d[1:0], s.rom[4:0]};
            rom_write = 1'b1;
          end
        end else if (a < 16'h8000) begin
          s.rom_mode = ~d[0];
        end
      end
      KIND_MBC2: begin
        // address bit 8 splits ROM bank select from RAM enable
        if (a < 16'h4000) begin
          if (a[8]) begin
            rom_next  = {s.rom[6:4], d[3:0]};
            rom_write = 1'b1;
          end else begin
            s.ram_en = (d[3:0] == RAM_EN_KEY);
          end
        end
      end
      KIND_MBC3: begin
        if (a < 16'h2000) begin
          s.ram_en = (d[3:0] == RAM_EN_KEY);
        end else if (a < 16'h4000) begin
          rom_next  = d[6:0];
          rom_write = 1'b1;
        end else if (a < 16'h6000) begin
          s.ram = d[1:0];
        end
      end
      default: begin
      end
    endcase
    // a zero ROM bank is never mapped
    if (rom_write) begin
      s.rom = (rom_next == '0) ? RomBankW'(1) : rom_next;
    end
    r.rom_bank    = s.rom;
    r.ram_bank    = s.ram;
    r.ram_enabled = s.ram_en;
    r.rom_changed = (s.rom != old_rom);
    r.ram_changed = (s.ram != old_ram);
    return r;
  endfunction

  function automatic dir_row_t dir_row(kind_t k, logic [15:0] a, logic [7:0] d,
                                       bit typed = 1'b0, logic [6:0] rom = '0,
                                       logic [1:0] ram = '0, logic en = 1'b0,
                                       logic rc = 1'b0, logic bc = 1'b0);
    dir_row_t row;
    row.kind  = k;
    row.addr  = a;
    row.wdata = d;
    row.typed = typed;
    row.want  = '{rom, ram, en, rc, bc};
    return row;
  endfunction

  // bus write with mostly meaningful addresses and data
  function automatic logic [23:0] random_write();
    logic [15:0] a;
    logic [7:0]  d;
    int          pick;
    pick = $urandom_range(99);
    a = 16'($urandom_range(16'h1FFF));
    if (pick < 22)      a = a;
    else if (pick < 50) a = a | 16'h2000;
    else if (pick < 72) a = a | 16'h4000;
    else if (pick < 88) a = a | 16'h6000;
    else                a = 16'($urandom_range(16'hFFFF, 16'h8000));
    pick = $urandom_range(99);
    d = 8'($urandom_range(255));
    // bank-zero values and the RAM enable key show up often
    if (pick < 15)      d = d & 8'hE0;
    else if (pick < 35) d = {d[7:4], RAM_EN_KEY};
    return {d, a};
  endfunction

  // one bus write beat; called and returns at a falling edge
  task automatic send_write(input logic [15:0] a, input logic [7:0] d,
                            input bit typed, input result_t typed_want);
    result_t predicted;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tdata  = {d, a};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    predicted = bank_update(mirror, a, d);
    expected_banks.push_back(typed ? typed_want : predicted);
    writes_sent++;
    @(negedge clk);
  endtask

  // stop sending and wait until every result has come back
  task automatic drain();
    in_tvalid = 1'b0;
    while (expected_banks.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
  endtask

  // controller kind write, only while idle
  task automatic set_kind(input kind_t k);
    drain();
    cfg_data  = k;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    mirror.kind = k;
    kind_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // result side: random stalls plus one long hold-off to back up the pipe
  initial begin
    out_tready = 1'b0;
    hold_done  = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && results_checked >= HoldAfter) begin
        out_tready = 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        out_tready = (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.rom_bank    = out_tdata[6:0];
      got.ram_bank    = out_tdata[8:7];
      got.ram_enabled = out_tdata[9];
      got.rom_changed = out_tdata[10];
      got.ram_changed = out_tdata[11];
      if (expected_banks.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: result beat with nothing expected: tdata=%h", $realtime, out_tdata);
      end else begin
        want = expected_banks.pop_front();
        results_checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("%0t: result %0d rom %h/%h ram %h/%h en %b/%b rom_chg %b/%b ram_chg %b/%b",
                     $realtime, results_checked, want.rom_bank, got.rom_bank,
                     want.ram_bank, got.ram_bank, want.ram_enabled, got.ram_enabled,
                     want.rom_changed, got.rom_changed, want.ram_changed, got.ram_changed);
        end
      end
    end
  end

  // watchdog on cycles where no beat moves on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("timeout: no beat for %0d cycles, %0d results outstanding", quiet_cycles,
               expected_banks.size());
      $display("[cartridge_bank_controller_core] ERROR");
      $finish;
    end
  end

  // stimulus
  initial begin
    kind_t       order[4];
    logic [23:0] wr;
    result_t     no_want;
    int          count;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    cfg_valid       = 1'b0;
    cfg_data        = KIND_NONE;
    rst_n           = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    writes_sent     = 0;
    results_checked = 0;
    kind_writes     = 0;
    mismatches      = 0;
    quiet_cycles    = 0;
    no_want         = '0;
    mirror.kind     = KIND_NONE;
    mirror.rom      = 7'd1;
    mirror.ram      = '0;
    mirror.ram_en   = 1'b0;
    mirror.rom_mode = 1'b1;

    // no banking after reset, then each kind's windows and edge values
    dir_rows.push_back(dir_row(KIND_NONE, 16'h2000, 8'h00, 1, 7'h01, 2'd0, 0, 0, 0));
    dir_rows.push_back(dir_row(KIND_MBC1, 16'h0000, 8'h0A, 1, 7'h01, 2'd0, 1, 0, 0));
    dir_rows.push_back(dir_row(KIND_MBC1, 16'h1FFF, 8'hFF, 1, 7'h01, 2'd0, 0, 0, 0));
    dir_rows.push_back(dir_row(KIND_MBC1, 16'h2000, 8'h00, 1, 7'h01, 2'd0, 0, 0, 0));
    dir_rows.push_back(dir_row(KIND_MBC1, 16'h3FFF, 8'h1F, 1, 7'h1F, 2'd0, 0, 1, 0));
    dir_rows.push_back(dir_row(KIND_MBC1, 16'h4000, 8'h03, 1, 7'h7F, 2'd0, 0, 1, 0));
    dir_rows.push_back(dir_row(KIND_MBC1, 16'h6000, 8'h01));
    dir_rows.push_back(dir_row(KIND_MBC1, 16'h5FFF, 8'hFF));
    dir_rows.push_back(dir_row(KIND_MBC1, 16'h7FFF, 8'hFE));
    dir_rows.push_back(dir_row(KIND_MBC1, 16'h4000, 8'h00));
    dir_rows.push_back(dir_row(KIND_MBC1, 16'h2000, 8'hE0));
    dir_rows.push_back(dir_row(KIND_MBC1, 16'h8000, 8'hFF));
    dir_rows.push_back(dir_row(KIND_MBC1, 16'hFFFF, 8'h00));
    dir_rows.push_back(dir_row(KIND_MBC2, 16'h0100, 8'hF0));
    dir_rows.push_back(dir_row(KIND_MBC2, 16'h3FFF, 8'h0F));
    dir_rows.push_back(dir_row(KIND_MBC2, 16'h3EFF, 8'h0A));
    dir_rows.push_back(dir_row(KIND_MBC2, 16'h4000, 8'hFF));
    dir_rows.push_back(dir_row(KIND_MBC3, 16'h2000, 8'h80));
    dir_rows.push_back(dir_row(KIND_MBC3, 16'h3FFF, 8'hFF));
    dir_rows.push_back(dir_row(KIND_MBC3, 16'h4000, 8'h0C));
    dir_rows.push_back(dir_row(KIND_MBC3, 16'h5FFF, 8'h0B));
    dir_rows.push_back(dir_row(KIND_MBC3, 16'h6000, 8'h01));
    dir_rows.push_back(dir_row(KIND_MBC3, 16'h0000, 8'h1A));
    // kind change back to none keeps the banks
    dir_rows.push_back(dir_row(KIND_NONE, 16'h0000, 8'h00));
    dir_rows.push_back(dir_row(KIND_NONE, 16'h2000, 8'h05));

    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed rows
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind != mirror.kind) set_kind(dir_rows[i].kind);
      send_write(dir_rows[i].addr, dir_rows[i].wdata, dir_rows[i].typed, dir_rows[i].want);
    end

    // random phases: none, sender gaps, receiver stalls, both
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 50 : (phase == 3) ? 22 : 0;
      recv_stall_pct = (phase == 2) ? 50 : (phase == 3) ? 22 : 0;
      for (int k = 0; k < 4; k++) order[k] = kind_t'((k + phase) % 4);
      for (int k = 0; k < 4; k++) begin
        if (order[k] != mirror.kind) set_kind(order[k]);
        count = (order[k] == KIND_NONE) ? NoneItems : MbcItems;
        for (int n = 0; n < count; n++) begin
          // one full pause mid-stream with the sender gapping
          if (phase == 1 && k == 0 && n == 50) drain();
          wr = random_write();
          send_write(wr[15:0], wr[23:16], 1'b0, no_want);
        end
      end
    end

    drain();
    $display("%0d bus writes over %0d kind settings (none, MBC1, MBC2, MBC3), %0d results checked",
             writes_sent, kind_writes, results_checked);
    $display("idle phases: none, sender gaps, receiver stalls, both; one long output hold-off");
    if (mismatches == 0) begin
      $display("[cartridge_bank_controller_core] OK");
    end else begin
      $display("%0d mismatching results", mismatches);
      $display("[cartridge_bank_controller_core] ERROR");
    end
    $finish;
  end

endmodule
